// ----- rtl/core/masr_pkg.sv -----
`timescale 1ns / 1ps

package masr_pkg;

  // Event codes carried by the request type field.
  typedef enum logic [1:0] {
    REQ_START    = 2'd0,
    REQ_POLL     = 2'd1,
    REQ_SPI_DONE = 2'd2,
    REQ_I2C_DONE = 2'd3
  } req_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_SPI_XFER = 2'd0,
    KIND_I2C_READ = 2'd1,
    KIND_SAMPLE   = 2'd2,
    KIND_FAIL     = 2'd3
  } kind_t;

  // Error codes of a failed read.
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BUS  = 2'd1,
    ERR_BUSY = 2'd2
  } err_t;

  // Configuration register indexes.
  localparam logic CFG_USE_SPI  = 1'b0;
  localparam logic CFG_I2C_ADDR = 1'b1;

  // Reset values of the configuration registers.
  localparam logic       USE_SPI_RESET  = 1'b1;
  localparam logic [7:0] I2C_ADDR_RESET = 8'h80;

  // Sensor register addresses.
  localparam logic [13:0] ADDR_AGC       = 14'h3ffd;
  localparam logic [13:0] ADDR_MAGNITUDE = 14'h3ffe;
  localparam logic [13:0] ADDR_ANGLE     = 14'h3fff;
  localparam logic [13:0] ADDR_NOP       = 14'h0000;
  localparam logic [7:0]  I2C_FIRST_REG  = 8'hfa;

  // Number of SPI transfers in one read.
  localparam logic [2:0] SPI_XFERS = 3'd4;

  // Sequencer state of one read.
  typedef struct packed {
    logic       active;
    logic [2:0] pos;
    logic       in_flight;
  } seq_state_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] spi_command;
    logic [7:0]  i2c_device;
    logic [7:0]  start_register;
    logic [31:0] sample_time_us;
    logic [7:0]  diagnostics;
    logic [7:0]  agc;
    logic [13:0] magnitude;
    logic [13:0] angle;
    err_t        fail_code;
  } result_t;

  // Read command: read bit set, even parity in the top bit.
  function automatic logic [15:0] spi_read_word(input logic [13:0] addr);
    logic [14:0] body;
    body = {1'b1, addr};
    return {^body, body};
  endfunction

  // Command issued at each position of the SPI sequence.
  function automatic logic [15:0] command_for(input logic [1:0] pos);
    logic [15:0] cmd;
    case (pos)
      2'd0:    cmd = spi_read_word(ADDR_AGC);
      2'd1:    cmd = spi_read_word(ADDR_MAGNITUDE);
      2'd2:    cmd = spi_read_word(ADDR_ANGLE);
      default: cmd = spi_read_word(ADDR_NOP);
    endcase
    return cmd;
  endfunction

endpackage

// ----- rtl/core/masr_step.sv -----
`timescale 1ns / 1ps

// Decodes one event against the current sequencer state and produces the
// next state, the response word writes and at most one result.
module masr_step (
  input  masr_pkg::seq_state_t st,
  input  logic                 use_spi,
  input  logic [7:0]           i2c_addr,
  input  logic [15:0]          word0,
  input  logic [15:0]          word1,
  input  logic [1:0]           req_type,
  input  logic [15:0]          rx_word,
  input  logic [47:0]          i2c_bytes,
  input  logic                 bus_failed,
  input  logic [31:0]          now_us,
  output masr_pkg::seq_state_t st_nxt,
  output logic                 word0_we,
  output logic                 word1_we,
  output logic                 res_valid,
  output masr_pkg::result_t    res
);

  always_comb begin
    st_nxt    = st;
    word0_we  = 1'b0;
    word1_we  = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    case (masr_pkg::req_t'(req_type))
      masr_pkg::REQ_START: begin
        if (st.active) begin
          // A second start leaves the read in progress alone.
          res_valid     = 1'b1;
          res.kind      = masr_pkg::KIND_FAIL;
          res.fail_code = masr_pkg::ERR_BUSY;
        end else begin
          st_nxt.active    = 1'b1;
          st_nxt.pos       = '0;
          st_nxt.in_flight = 1'b0;
          if (!use_spi) begin
            res_valid          = 1'b1;
            res.kind           = masr_pkg::KIND_I2C_READ;
            res.i2c_device     = i2c_addr;
            res.start_register = masr_pkg::I2C_FIRST_REG;
          end
        end
      end

      masr_pkg::REQ_POLL: begin
        // Issue the next transfer when the bus is free and one is still due.
        if (st.active && use_spi && !st.in_flight && (st.pos < masr_pkg::SPI_XFERS)) begin
          res_valid        = 1'b1;
          res.kind         = masr_pkg::KIND_SPI_XFER;
          res.spi_command  = masr_pkg::command_for(st.pos[1:0]);
          st_nxt.pos       = st.pos + 3'd1;
          st_nxt.in_flight = 1'b1;
        end
      end

      masr_pkg::REQ_SPI_DONE: begin
        if (st.active && use_spi && st.in_flight) begin
          st_nxt.in_flight = 1'b0;
          if (bus_failed) begin
            st_nxt        = '0;
            res_valid     = 1'b1;
            res.kind      = masr_pkg::KIND_FAIL;
            res.fail_code = masr_pkg::ERR_BUS;
          end else if (st.pos == masr_pkg::SPI_XFERS) begin
            // The last response carries the angle and is used directly.
            st_nxt             = '0;
            res_valid          = 1'b1;
            res.kind           = masr_pkg::KIND_SAMPLE;
            res.sample_time_us = now_us;
            res.diagnostics    = {4'd0, word0[11:8]};
            res.agc            = word0[7:0];
            res.magnitude      = word1[13:0];
            res.angle          = rx_word[13:0];
          end else begin
            // Responses are delayed by one transfer: keep AGC and magnitude.
            word0_we = (st.pos == 3'd2);
            word1_we = (st.pos == 3'd3);
          end
        end
      end

      default: begin
        // I2C read completion.
        if (st.active && !use_spi) begin
          st_nxt    = '0;
          res_valid = 1'b1;
          if (bus_failed) begin
            res.kind      = masr_pkg::KIND_FAIL;
            res.fail_code = masr_pkg::ERR_BUS;
          end else begin
            res.kind           = masr_pkg::KIND_SAMPLE;
            res.sample_time_us = now_us;
            res.agc            = i2c_bytes[47:40];
            res.diagnostics    = i2c_bytes[39:32];
            res.magnitude      = {i2c_bytes[31:24], i2c_bytes[21:16]};
            res.angle          = {i2c_bytes[15:8], i2c_bytes[5:0]};
          end
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/magnetic_angle_sensor_reader.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------
// in_      | input     | in_valid / in_stall | req_type, rx_word, i2c_bytes, ...
// out_     | output    | out_valid/out_stall | kind, spi_command, ..., fail_code
// cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One event is decoded per cycle while in_stall is low; its result, if any, is
// registered and shown on the cycle after the transfer unless an earlier result
// is still held. The output register is backed by a one-entry skid stage;
// in_stall rises only when that skid stage holds a result. Reset (synchronous,
// active low) idles the sequencer, empties both stages and restores the
// configuration registers.
module magnetic_angle_sensor_reader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_rx_word,
  input  logic [47:0] in_i2c_bytes,
  input  logic        in_bus_failed,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_spi_command,
  output logic [7:0]  out_i2c_device,
  output logic [7:0]  out_start_register,
  output logic [31:0] out_sample_time_us,
  output logic [7:0]  out_diagnostics,
  output logic [7:0]  out_agc,
  output logic [13:0] out_magnitude,
  output logic [13:0] out_angle,
  output logic [1:0]  out_fail_code
);

  logic                 use_spi_r;
  logic [7:0]           i2c_addr_r;
  masr_pkg::seq_state_t st_r;
  masr_pkg::seq_state_t st_nxt;
  logic [15:0]          word0_r;
  logic [15:0]          word1_r;
  logic                 word0_we;
  logic                 word1_we;
  logic                 res_valid;
  masr_pkg::result_t    res;
  logic                 in_xfer;
  logic                 new_res;
  logic                 out_free;
  logic                 out_valid_r;
  masr_pkg::result_t    out_r;
  logic                 skid_valid_r;
  masr_pkg::result_t    skid_r;

  assign in_xfer  = in_valid && !in_stall;
  assign new_res  = in_xfer && res_valid;
  assign out_free = !out_valid_r || !out_stall;

  masr_step u_step (
    .st         (st_r),
    .use_spi    (use_spi_r),
    .i2c_addr   (i2c_addr_r),
    .word0      (word0_r),
    .word1      (word1_r),
    .req_type   (in_req_type),
    .rx_word    (in_rx_word),
    .i2c_bytes  (in_i2c_bytes),
    .bus_failed (in_bus_failed),
    .now_us     (in_now_us),
    .st_nxt     (st_nxt),
    .word0_we   (word0_we),
    .word1_we   (word1_we),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_spi_r  <= masr_pkg::USE_SPI_RESET;
      i2c_addr_r <= masr_pkg::I2C_ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        masr_pkg::CFG_USE_SPI:  use_spi_r  <= cfg_wdata[0];
        masr_pkg::CFG_I2C_ADDR: i2c_addr_r <= cfg_wdata;
        default:                use_spi_r  <= use_spi_r;
      endcase
    end
  end

  // Sequencer state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Kept SPI responses (AGC and magnitude words).
  always_ff @(posedge clk) begin
    if (in_xfer && word0_we) begin
      word0_r <= in_rx_word;
    end
    if (in_xfer && word1_we) begin
      word1_r <= in_rx_word;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= new_res;
      end else begin
        out_valid_r  <= new_res;
      end
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (new_res) begin
          skid_r <= res;
        end
      end else if (new_res) begin
        out_r <= res;
      end
    end else if (new_res) begin
      skid_r <= res;
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_spi_command    = out_r.spi_command;
  assign out_i2c_device     = out_r.i2c_device;
  assign out_start_register = out_r.start_register;
  assign out_sample_time_us = out_r.sample_time_us;
  assign out_diagnostics    = out_r.diagnostics;
  assign out_agc            = out_r.agc;
  assign out_magnitude      = out_r.magnitude;
  assign out_angle          = out_r.angle;
  assign out_fail_code      = out_r.fail_code;

endmodule

// ----- rtl/core/masr_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks of the sensor reader.
module masr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [15:0] out_spi_command,
  input logic [1:0]  out_fail_code
);

  // The skid stage only fills behind a held output.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Nothing is shown after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall survived reset");

  // A stalled result stays offered.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind))
    else $error("stalled result dropped or changed");

  // Error code and command appear only with their result kinds.
  a_fields_match_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_kind == masr_pkg::KIND_FAIL) == (out_fail_code != masr_pkg::ERR_NONE)) &&
      ((out_kind == masr_pkg::KIND_SPI_XFER) || (out_spi_command == 16'd0)))
    else $error("result fields do not match result kind");

endmodule

bind magnetic_angle_sensor_reader masr_checker u_masr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_spi_command (out_spi_command),
  .out_fail_code   (out_fail_code)
);
